@@ sv/ghh_pkg.sv @@
`timescale 1ns / 1ps

package ghh_pkg;

    localparam int GHH_MAX_POINTS = 4096;
    localparam int GHH_NUM_BINS   = 30;

    // bin geometry: bin = trunc((z + BIN_BASE_MM) / BIN_WIDTH_MM)
    localparam int BIN_BASE_MM  = 2000;
    localparam int BIN_WIDTH_MM = 100;

    // divide by 100 as multiply and shift, exact for dividends below 43690
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;

    localparam int Z_W         = 16;
    localparam int HALF_W      = 12;
    localparam int GROUND_W    = 13;
    localparam int CUBE_W      = 14;
    localparam int STATUS_W    = 2;
    localparam int OUT_TDATA_W = 32;

    localparam logic [HALF_W-1:0] HALF_RESET = 12'd400;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED    = 2'd0,
        ST_NOT_DOWN   = 2'd1,
        ST_NO_PEAK    = 2'd2,
        ST_FEW_POINTS = 2'd3
    } t_status;

endpackage

@@ sv/ghh_bin_mem.sv @@
`timescale 1ns / 1ps

module ghh_bin_mem
    import ghh_pkg::*;
#(
    parameter int DEPTH = GHH_NUM_BINS,
    parameter int WIDTH = 40
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/ghh_div.sv @@
`timescale 1ns / 1ps

module ghh_div
    import ghh_pkg::*;
#(
    parameter int DVD_W = 29,
    parameter int DVS_W = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // one quotient bit per cycle, restoring
    always_comb begin
        w_shift = {r_rem, r_quot[DVD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[DVD_W-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

@@ sv/ground_height_histogram.sv @@
`timescale 1ns / 1ps

// Ground height histogram. Point heights (mm) stream in on s_axis at one item per cycle;
// each in range lands in a 100 mm bin whose count and height sum live in a one-port-read,
// one-port-write memory updated by read-modify-write with a forwarding register for
// back-to-back hits on the same bin. The item marked tlast closes the cloud: s_axis_tready
// then drops while the last update is written back, the bins are searched for the peak,
// the status is evaluated and, for status 0, the mean is computed; one memory read per
// bin for the peak search, which also clears the bins, and the serial divider for the
// mean, one quotient bit per cycle, make up the drop, which lasts longer while the
// previous result item still waits on m_axis. One result item per cloud leaves on m_axis:
// status 0 updated, 1 not looking down, 2 no occupied bin among bins 1 to NUM_BINS - 2,
// 3 too few points; heights are zero unless status is 0. After reset every bin is cleared
// before the first item is taken. The user must write the cube half size register through
// i_cfg_we / i_cfg_wdata only while the block is idle; the block does not enforce this.

module ground_height_histogram
    import ghh_pkg::*;
#(
    parameter int MAX_POINTS = GHH_MAX_POINTS,
    parameter int NUM_BINS   = GHH_NUM_BINS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [HALF_W-1:0]      i_cfg_wdata,      // cube_half_size_mm
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [Z_W-1:0]         s_axis_tdata,     // [15:0] point_z_mm
    input  logic                   s_axis_tlast,     // last_point
    input  logic                   s_axis_tuser,     // looking_down
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata      // [1:0] status, [14:2] ground_height_mm,
                                                     // [28:15] cube_center_z_mm, rest zero
);

    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int IDX_W  = $clog2(NUM_BINS);
    localparam int ZMAG_W = $clog2(BIN_BASE_MM + NUM_BINS * BIN_WIDTH_MM) + 1;
    localparam int SUM_W  = CNT_W + ZMAG_W;
    localparam int WORD_W = CNT_W + SUM_W;
    localparam int N3_W   = CNT_W + 2;
    localparam int S3_W   = SUM_W + 2;
    localparam int V_W    = Z_W + 1;
    localparam int PROD_W = Z_W + RECIP_W;
    localparam int Q_W    = PROD_W - RECIP_SHIFT;
    localparam int PAD_W  = OUT_TDATA_W - STATUS_W - GROUND_W - CUBE_W;

    localparam logic [IDX_W-1:0] LAST_BIN = IDX_W'(NUM_BINS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);

    typedef enum logic [2:0] {
        S_INIT, S_RUN, S_FLUSH, S_SCAN, S_TAIL, S_EVAL, S_DIV, S_OUT
    } t_state;

    t_state r_state;

    logic [HALF_W-1:0] r_half;
    logic [CNT_W-1:0]  r_total;
    logic              r_down;
    logic [IDX_W-1:0]  r_addr;

    // update stage
    logic              r_p1_vld;
    logic              r_p1_hit;
    logic [IDX_W-1:0]  r_p1_idx;
    logic [Z_W-1:0]    r_p1_z;

    // last word written, for a read that raced its write
    logic              r_fwd_vld;
    logic [IDX_W-1:0]  r_fwd_addr;
    logic [WORD_W-1:0] r_fwd_word;

    // peak search window
    logic              r_rd_vld;
    logic [IDX_W-1:0]  r_rd_addr;
    logic [CNT_W-1:0]  r_w1_cnt;
    logic [CNT_W-1:0]  r_w2_cnt;
    logic [SUM_W-1:0]  r_w1_sum;
    logic [SUM_W-1:0]  r_w2_sum;
    logic [CNT_W-1:0]  r_best;
    logic              r_found;
    logic [N3_W-1:0]   r_n3;
    logic [S3_W-1:0]   r_s3;

    logic              r_div_start;
    logic [S3_W-1:0]   r_div_dvd;
    logic              r_neg;

    t_status             r_res_status;
    logic [GROUND_W-1:0] r_res_ground;
    logic [CUBE_W-1:0]   r_res_cube;

    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic              w_in_acc;
    logic signed [V_W-1:0] w_v;
    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    w_q;
    logic              w_hit;
    logic [IDX_W-1:0]  w_idx;

    logic [WORD_W-1:0] w_rdata;
    logic [WORD_W-1:0] w_cur;
    logic [CNT_W-1:0]  w_cur_cnt;
    logic [SUM_W-1:0]  w_cur_sum;
    logic              w_p1_wr;
    logic [WORD_W-1:0] w_upd_word;

    logic              w_clearing;
    logic              w_mem_we;
    logic [IDX_W-1:0]  w_mem_waddr;
    logic [WORD_W-1:0] w_mem_wdata;
    logic [IDX_W-1:0]  w_mem_raddr;

    logic [S3_W-1:0]   w_s3_mag;
    logic              w_div_done;
    logic [S3_W-1:0]   w_quot;
    logic [S3_W-1:0]   w_qs;
    logic              w_out_free;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_RUN);

    // bin index, truncating toward zero
    always_comb begin
        w_v    = $signed({s_axis_tdata[Z_W-1], s_axis_tdata}) + V_W'(BIN_BASE_MM);
        w_prod = PROD_W'(w_v[Z_W-1:0]) * PROD_W'(RECIP_100);
        w_q    = w_prod[PROD_W-1:RECIP_SHIFT];
        w_hit  = (w_v > -V_W'(BIN_WIDTH_MM)) && (w_v[V_W-1] || (w_q < Q_W'(NUM_BINS)));
        w_idx  = w_v[V_W-1] ? '0 : w_q[IDX_W-1:0];
    end

    always_comb begin
        w_cur      = (r_fwd_vld && (r_fwd_addr == r_p1_idx)) ? r_fwd_word : w_rdata;
        w_cur_cnt  = w_cur[WORD_W-1:SUM_W];
        w_cur_sum  = w_cur[SUM_W-1:0];
        w_p1_wr    = r_p1_vld && r_p1_hit && (w_cur_cnt < CNT_MAX);
        w_upd_word = {w_cur_cnt + 1'b1,
                      w_cur_sum + {{(SUM_W - Z_W){r_p1_z[Z_W-1]}}, r_p1_z}};
    end

    // bins are zeroed in the init pass and as the search reads them
    always_comb begin
        w_clearing  = (r_state == S_INIT) || (r_state == S_SCAN);
        w_mem_we    = w_clearing || w_p1_wr;
        w_mem_waddr = w_clearing ? r_addr : r_p1_idx;
        w_mem_wdata = w_clearing ? '0 : w_upd_word;
        w_mem_raddr = (r_state == S_SCAN) ? r_addr : w_idx;
    end

    ghh_bin_mem #(
        .DEPTH (NUM_BINS),
        .WIDTH (WORD_W)
    ) u_bin_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    ghh_div #(
        .DVD_W (S3_W),
        .DVS_W (N3_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_n3),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        w_s3_mag   = r_s3[S3_W-1] ? (~r_s3 + 1'b1) : r_s3;
        w_qs       = r_neg ? (~w_quot + 1'b1) : w_quot;
        w_out_free = !r_out_vld || m_axis_tready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_half      <= HALF_RESET;
            r_total     <= '0;
            r_down      <= 1'b0;
            r_addr      <= '0;
            r_p1_vld    <= 1'b0;
            r_fwd_vld   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_best      <= '0;
            r_found     <= 1'b0;
            r_div_start <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half <= i_cfg_wdata;
            end

            r_p1_vld <= w_in_acc;
            r_p1_hit <= w_hit;
            r_p1_idx <= w_idx;
            r_p1_z   <= s_axis_tdata;

            if (w_p1_wr) begin
                r_fwd_vld  <= 1'b1;
                r_fwd_addr <= r_p1_idx;
                r_fwd_word <= w_upd_word;
            end else if (r_state == S_SCAN) begin
                r_fwd_vld <= 1'b0;
            end

            r_rd_vld  <= (r_state == S_SCAN);
            r_rd_addr <= r_addr;
            if (r_rd_vld) begin
                // center bin is the one read before the current one
                if ((r_rd_addr >= IDX_W'(2)) && (r_w1_cnt > r_best)) begin
                    r_best  <= r_w1_cnt;
                    r_found <= 1'b1;
                    r_n3    <= N3_W'(r_w2_cnt) + N3_W'(r_w1_cnt) + N3_W'(w_rdata[WORD_W-1:SUM_W]);
                    r_s3    <= {{2{r_w2_sum[SUM_W-1]}}, r_w2_sum}
                             + {{2{r_w1_sum[SUM_W-1]}}, r_w1_sum}
                             + {{2{w_rdata[SUM_W-1]}}, w_rdata[SUM_W-1:0]};
                end
                r_w2_cnt <= r_w1_cnt;
                r_w2_sum <= r_w1_sum;
                r_w1_cnt <= w_rdata[WORD_W-1:SUM_W];
                r_w1_sum <= w_rdata[SUM_W-1:0];
            end

            if (r_state != S_EVAL) begin
                r_div_start <= 1'b0;
            end

            // a new result item in S_OUT takes the place of the one leaving
            if (m_axis_tvalid && m_axis_tready && (r_state != S_OUT)) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_INIT: begin
                    if (r_addr == LAST_BIN) begin
                        r_addr  <= '0;
                        r_state <= S_RUN;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_RUN: begin
                    if (w_in_acc) begin
                        if (r_total < CNT_MAX) begin
                            r_total <= r_total + 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_down  <= s_axis_tuser;
                            r_state <= S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    // last item is written back in this cycle
                    r_best  <= '0;
                    r_found <= 1'b0;
                    r_addr  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (r_addr == LAST_BIN) begin
                        r_addr  <= '0;
                        r_state <= S_TAIL;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_TAIL: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_res_ground <= '0;
                    r_res_cube   <= '0;
                    r_neg        <= r_s3[S3_W-1];
                    r_div_dvd    <= w_s3_mag;
                    if (!r_down) begin
                        r_res_status <= ST_NOT_DOWN;
                        r_div_start  <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (!r_found) begin
                        r_res_status <= ST_NO_PEAK;
                        r_div_start  <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (r_n3 < N3_W'(r_total >> 1)) begin
                        r_res_status <= ST_FEW_POINTS;
                        r_div_start  <= 1'b0;
                        r_state      <= S_OUT;
                    end else begin
                        r_res_status <= ST_UPDATED;
                        r_div_start  <= 1'b1;
                        r_state      <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res_ground <= w_qs[GROUND_W-1:0];
                        r_res_cube   <= w_qs[CUBE_W-1:0] + CUBE_W'(r_half);
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= {{PAD_W{1'b0}}, r_res_cube, r_res_ground, r_res_status};
                        r_total    <= '0;
                        r_state    <= S_RUN;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ dv/ground_height_histogram_checker.sv @@
`timescale 1ns / 1ps

module ground_height_histogram_checker
    import ghh_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [HALF_W-1:0]      i_cfg_wdata,      // cube_half_size_mm
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [Z_W-1:0]         s_axis_tdata,     // [15:0] point_z_mm
    input  logic                   s_axis_tlast,     // last_point
    input  logic                   s_axis_tuser,     // looking_down
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,     // [1:0] status, [14:2] ground_height_mm,
                                                     // [28:15] cube_center_z_mm, rest zero
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked
);

    localparam int GROUND_LSB = STATUS_W;
    localparam int CUBE_LSB   = GROUND_LSB + GROUND_W;
    localparam int PAD_LSB    = CUBE_LSB + CUBE_W;

    typedef struct packed {
        t_status             status;
        logic [GROUND_W-1:0] ground;
        logic [CUBE_W-1:0]   cube;
    } t_ground_fix;

    int                  bin_pts [GHH_NUM_BINS];
    longint              bin_zsum [GHH_NUM_BINS];
    int                  cloud_pts;
    logic [HALF_W-1:0]   half_size;
    t_ground_fix         ground_fix_q [$];
    t_ground_fix         fix_head;
    logic [STATUS_W-1:0] got_status;
    logic [GROUND_W-1:0] got_ground;
    logic [CUBE_W-1:0]   got_cube;
    logic [OUT_TDATA_W-PAD_LSB-1:0] got_pad;
    int                  fail_count;
    int                  checked;

    task automatic clear_bins();
        for (int i = 0; i < GHH_NUM_BINS; i++) begin
            bin_pts[i]  = 0;
            bin_zsum[i] = 0;
        end
        cloud_pts = 0;
    endtask

    // bins one point and, on the last point of a cloud, queues the ground fix it yields
    task automatic bin_point(input logic [Z_W-1:0] zraw, input logic last, input logic down);
        int          z;
        int          idx;
        int          best;
        int          peak;
        int          n;
        longint      s;
        longint      gnd;
        longint      cube;
        t_ground_fix fix;
        z   = int'($signed(zraw));
        idx = (z + BIN_BASE_MM) / BIN_WIDTH_MM;
        if (cloud_pts < GHH_MAX_POINTS)
            cloud_pts++;
        if (idx >= 0 && idx < GHH_NUM_BINS && bin_pts[idx] < GHH_MAX_POINTS) begin
            bin_pts[idx]++;
            bin_zsum[idx] += z;
        end
        if (!last)
            return;
        gnd  = 0;
        cube = 0;
        if (!down) begin
            fix.status = ST_NOT_DOWN;
        end else begin
            best = 0;
            peak = -1;
            for (int i = 1; i < GHH_NUM_BINS - 1; i++) begin
                if (bin_pts[i] > best) begin
                    best = bin_pts[i];
                    peak = i;
                end
            end
            if (peak < 0) begin
                fix.status = ST_NO_PEAK;
            end else begin
                n = bin_pts[peak-1] + bin_pts[peak] + bin_pts[peak+1];
                s = bin_zsum[peak-1] + bin_zsum[peak] + bin_zsum[peak+1];
                if (n < cloud_pts / 2) begin
                    fix.status = ST_FEW_POINTS;
                end else begin
                    fix.status = ST_UPDATED;
                    gnd  = s / n;   // truncates toward zero
                    cube = gnd + half_size;
                end
            end
        end
        fix.ground = gnd[GROUND_W-1:0];
        fix.cube   = cube[CUBE_W-1:0];
        ground_fix_q.insert(ground_fix_q.size(), fix);
        clear_bins();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_bins();
            half_size = HALF_RESET;
            ground_fix_q.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_status = m_axis_tdata[GROUND_LSB-1:0];
                got_ground = m_axis_tdata[CUBE_LSB-1:GROUND_LSB];
                got_cube   = m_axis_tdata[PAD_LSB-1:CUBE_LSB];
                got_pad    = m_axis_tdata[OUT_TDATA_W-1:PAD_LSB];
                if (ground_fix_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result item %h with no cloud pending", $time,
                                 m_axis_tdata);
                    fail_count++;
                end else begin
                    fix_head = ground_fix_q.pop_front();
                    if (got_status !== fix_head.status || got_ground !== fix_head.ground ||
                        got_cube !== fix_head.cube || got_pad !== '0) begin
                        if (fail_count < 10)
                            $display("%0t: status %0d/%0d ground %0d/%0d cube %0d/%0d pad %h",
                                     $time, fix_head.status, got_status,
                                     $signed(fix_head.ground), $signed(got_ground),
                                     $signed(fix_head.cube), $signed(got_cube), got_pad);
                        fail_count++;
                    end
                end
                checked++;
            end
            if (s_axis_tvalid && s_axis_tready)
                bin_point(s_axis_tdata, s_axis_tlast, s_axis_tuser);
            if (i_cfg_we)
                half_size = i_cfg_wdata;
        end
        o_fail_count = fail_count;
        o_pending    = ground_fix_q.size();
        o_checked    = checked;
    end

endmodule

@@ dv/ground_height_histogram_tb.sv @@
`timescale 1ns / 1ps

module ground_height_histogram_tb;
    import ghh_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int BUSY_CYCLES  = 80;     // end-of-cloud scan and divide, with margin
    localparam int PHASE_POINTS = 220;
    localparam int SEND_IDLE [4]  = '{0, 83, 0, 38};
    localparam int RECV_STALL [4] = '{0, 0, 83, 38};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [HALF_W-1:0]      i_cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [Z_W-1:0]         s_axis_tdata = '0;     // [15:0] point_z_mm
    logic                   s_axis_tlast = 1'b0;   // last_point
    logic                   s_axis_tuser = 1'b0;   // looking_down
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // [1:0] status, [14:2] ground_height_mm,
                                                   // [28:15] cube_center_z_mm, rest zero

    int                fail_count;
    int                pending;
    int                checked;
    int                cycles = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                points_sent = 0;
    int                clouds_sent = 0;
    int                phase_start;
    logic [HALF_W-1:0] phase_half [4];

    ground_height_histogram dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ground_height_histogram_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles, %0d results outstanding", cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the item is taken
    task automatic send_point(input int z, input logic last, input logic down);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= z[Z_W-1:0];
        s_axis_tlast  <= last;
        s_axis_tuser  <= down;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        @(negedge i_clk);
        points_sent++;
        if (last)
            clouds_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge i_clk);
        while (pending != 0);
    endtask

    task automatic write_half(input logic [HALF_W-1:0] value);
        drain_results();
        repeat (BUSY_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly a ground cluster with noise; some scattered, peakless or fully random clouds
    task automatic send_random_cloud();
        int   size;
        int   kind;
        int   g;
        int   z;
        int   r;
        logic down;
        size = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
        kind = $urandom_range(0, 9);
        g    = $urandom_range(0, 2900) - 2000;
        down = ($urandom_range(0, 9) != 0);
        for (int k = 0; k < size; k++) begin
            r = $urandom_range(0, 99);
            if (kind == 8) begin
                case (r % 4)
                    0: z = $urandom_range(0, 198) - 2099;
                    1: z = $urandom_range(900, 999);
                    2: z = -2100 - int'($urandom_range(0, 30668));
                    default: z = $urandom_range(1000, 32767);
                endcase
            end else if (kind == 9 || r < 4) begin
                z = $urandom_range(0, 65535);
            end else if (kind >= 6 || r < 20) begin
                z = $urandom_range(0, 3400) - 2200;
            end else begin
                z = g + $urandom_range(0, 300) - 150;
            end
            if (k == size - 1)
                send_point(z, 1'b1, down);
            else
                send_point(z, 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    initial begin
        phase_half[0] = '0;
        phase_half[1] = 12'd4000;
        phase_half[2] = 12'($urandom_range(1, 3999));
        phase_half[3] = 12'($urandom_range(1, 3999));
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // only out of range points and both edge bins: no candidate peak
        send_point(-32768, 1'b0, 1'b1);
        send_point(32767, 1'b0, 1'b0);
        send_point(-2100, 1'b0, 1'b1);
        send_point(1000, 1'b0, 1'b0);
        send_point(-2001, 1'b0, 1'b1);
        send_point(999, 1'b1, 1'b1);
        // not looking down beats a clear peak
        send_point(-500, 1'b0, 1'b1);
        send_point(-500, 1'b1, 1'b0);
        // the occupied candidate bins tie at one point each, lowest wins and holds too few points
        send_point(-2099, 1'b0, 1'b0);
        send_point(-1500, 1'b0, 1'b1);
        send_point(500, 1'b0, 1'b0);
        send_point(900, 1'b0, 1'b1);
        send_point(-500, 1'b1, 1'b1);
        // negative mean truncates toward zero, bin 0 as neighbour
        send_point(-1901, 1'b0, 1'b1);
        send_point(-1899, 1'b0, 1'b0);
        send_point(-1899, 1'b0, 1'b1);
        send_point(-1800, 1'b0, 1'b0);
        send_point(-1950, 1'b1, 1'b1);
        // peak at the top candidate bin with bin 29 as neighbour
        send_point(899, 1'b0, 1'b1);
        send_point(850, 1'b0, 1'b0);
        send_point(999, 1'b0, 1'b1);
        send_point(801, 1'b1, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            write_half(phase_half[phase]);
            send_idle_pct  = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            phase_start = points_sent;
            while (points_sent - phase_start < PHASE_POINTS) begin
                send_random_cloud();
                if ($urandom_range(0, 7) == 0)
                    drain_results();
            end
        end

        drain_results();
        repeat (BUSY_CYCLES) @(negedge i_clk);
        $display("covered %0d points in %0d clouds, %0d result items checked, over four",
                 points_sent, clouds_sent, checked);
        $display("handshake mixes, cube half sizes 0 to 4000 and directed edge-bin clouds");
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
